>>> rtl/hsl_pkg.sv
// Shared constants, codes and stage types for the HSL to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsl_pkg;

  localparam int FRAC_BITS = 16;

  localparam int IN_W     = 9;
  localparam int LVL_W    = 8;
  localparam int FX_W     = FRAC_BITS + 1;
  localparam int FACT_W   = FRAC_BITS + 2;
  localparam int VAL_W    = FRAC_BITS + 3;
  localparam int SCALE_SH = FRAC_BITS - 8;

  localparam longint unsigned ONE64 = 64'd1 << FRAC_BITS;

  localparam logic [FX_W-1:0] FX_ONE        = FX_W'(ONE64);
  localparam logic [FX_W-1:0] FX_HALF       = FX_W'(ONE64 / 2);
  localparam logic [FX_W-1:0] FX_THIRD      = FX_W'(ONE64 / 3);
  localparam logic [FX_W-1:0] FX_TWO_THIRDS = FX_W'((2 * ONE64) / 3);

  // hue / 360 as multiply by a rounded-up reciprocal; exact for hue < 360
  localparam int HUE_SHIFT   = 17;
  localparam int HUE_RECIP_W = FRAC_BITS + 9;
  localparam logic [HUE_RECIP_W-1:0] HUE_RECIP =
    HUE_RECIP_W'(((64'd1 << (FRAC_BITS + HUE_SHIFT)) + 64'd359) / 64'd360);

  localparam logic [IN_W-1:0]  HUE_WRAP = 9'd360;
  localparam logic [IN_W-1:0]  UNIT_MAX = 9'd256;
  localparam logic [LVL_W-1:0] LVL_MAX  = 8'd255;

  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_HIGH = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LOW  = 2'd3
  } seg_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] h;
    logic [FX_W-1:0]      l;
    logic [FX_W-1:0]      s;
    logic [FX_W-1:0]      prod_a;
    logic [FX_W-1:0]      prod_b;
    logic                 lit_low;
    logic                 gray;
  } prep_t;

  typedef struct packed {
    seg_t              seg;
    logic [FACT_W-1:0] factor;
    logic [FX_W-1:0]   lo;
    logic [FX_W-1:0]   hi;
    logic [FX_W-1:0]   span;
  } chan_t;

endpackage

`default_nettype wire

>>> rtl/hsl_prep.sv
// Stage 1: input normalization, hue fraction and lightness/saturation products.
`timescale 1ns / 1ps
`default_nettype none

module hsl_prep (
  input  wire                          clk,
  input  wire                          en,
  input  wire [hsl_pkg::IN_W-1:0]      hue_degrees,
  input  wire [hsl_pkg::IN_W-1:0]      saturation,
  input  wire [hsl_pkg::IN_W-1:0]      lightness,
  output hsl_pkg::prep_t               prep_o
);

  localparam int HP_W = hsl_pkg::IN_W + hsl_pkg::HUE_RECIP_W;
  localparam int PA_W = 2 * hsl_pkg::FX_W + 1;
  localparam int PB_W = 2 * hsl_pkg::FX_W;

  logic [hsl_pkg::IN_W-1:0]   hue_n;
  logic [hsl_pkg::IN_W-1:0]   sat_c;
  logic [hsl_pkg::IN_W-1:0]   lit_c;
  logic [hsl_pkg::FX_W-1:0]   s_fx;
  logic [hsl_pkg::FX_W-1:0]   l_fx;
  logic [hsl_pkg::FX_W:0]     one_plus_s;
  logic [HP_W-1:0]            hue_prod;
  logic [PA_W-1:0]            prod_a_full;
  logic [PB_W-1:0]            prod_b_full;
  hsl_pkg::prep_t             prep_nxt;
  hsl_pkg::prep_t             prep_r;

  always_comb begin
    hue_n = (hue_degrees >= hsl_pkg::HUE_WRAP) ? hue_degrees - hsl_pkg::HUE_WRAP : hue_degrees;
    sat_c = (saturation > hsl_pkg::UNIT_MAX) ? hsl_pkg::UNIT_MAX : saturation;
    lit_c = (lightness > hsl_pkg::UNIT_MAX) ? hsl_pkg::UNIT_MAX : lightness;
    s_fx  = hsl_pkg::FX_W'(sat_c) << hsl_pkg::SCALE_SH;
    l_fx  = hsl_pkg::FX_W'(lit_c) << hsl_pkg::SCALE_SH;
    one_plus_s  = (hsl_pkg::FX_W + 1)'(hsl_pkg::FX_ONE) + (hsl_pkg::FX_W + 1)'(s_fx);
    hue_prod    = HP_W'(hue_n) * HP_W'(hsl_pkg::HUE_RECIP);
    prod_a_full = PA_W'(l_fx) * PA_W'(one_plus_s);
    prod_b_full = PB_W'(l_fx) * PB_W'(s_fx);

    prep_nxt.h       = hue_prod[hsl_pkg::HUE_SHIFT +: hsl_pkg::FRAC_BITS];
    prep_nxt.l       = l_fx;
    prep_nxt.s       = s_fx;
    prep_nxt.prod_a  = prod_a_full[hsl_pkg::FRAC_BITS +: hsl_pkg::FX_W];
    prep_nxt.prod_b  = prod_b_full[hsl_pkg::FRAC_BITS +: hsl_pkg::FX_W];
    prep_nxt.lit_low = (l_fx < hsl_pkg::FX_HALF);
    prep_nxt.gray    = (sat_c == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign prep_o = prep_r;

endmodule

`default_nettype wire

>>> rtl/hsl_chroma.sv
// Stage 2: chroma terms, per-channel hue position and ramp segment select.
`timescale 1ns / 1ps
`default_nettype none

module hsl_chroma (
  input  wire                          clk,
  input  wire                          en,
  input  wire hsl_pkg::prep_t          prep_i,
  output hsl_pkg::chan_t [2:0]         chan_o
);

  localparam int FW = hsl_pkg::FX_W;

  logic [FW:0]     sum_hi;
  logic [FW:0]     dbl_l;
  logic [FW-1:0]   v1;
  logic [FW-1:0]   v2;
  logic [FW-1:0]   span;
  logic [FW-1:0]   h_fx;
  logic [FW-1:0]   pos_red;
  logic [FW-1:0]   pos_blue;
  logic [FW-1:0]   pos_green;
  hsl_pkg::chan_t [2:0] chan_nxt;
  hsl_pkg::chan_t [2:0] chan_r;

  function automatic hsl_pkg::chan_t make_chan(
    input logic [FW-1:0] pos,
    input logic [FW-1:0] lo,
    input logic [FW-1:0] hi,
    input logic [FW-1:0] sp,
    input logic [FW-1:0] gray_l,
    input logic          gray
  );
    hsl_pkg::chan_t c;
    logic [FW+2:0]  six_pos;
    logic [FW+2:0]  one_x;
    logic [FW+2:0]  two_pos;
    logic [FW+2:0]  three_pos;
    logic [FW-1:0]  rest;
    logic [FW+2:0]  six_rest;
    six_pos   = ((FW + 3)'(pos) << 2) + ((FW + 3)'(pos) << 1);
    two_pos   = (FW + 3)'(pos) << 1;
    three_pos = two_pos + (FW + 3)'(pos);
    one_x     = (FW + 3)'(hsl_pkg::FX_ONE);
    rest      = (pos > hsl_pkg::FX_TWO_THIRDS) ? '0 : hsl_pkg::FX_TWO_THIRDS - pos;
    six_rest  = ((FW + 3)'(rest) << 2) + ((FW + 3)'(rest) << 1);
    c.lo   = lo;
    c.hi   = hi;
    c.span = sp;
    if (six_pos < one_x) begin
      c.seg    = hsl_pkg::SEG_RISE;
      c.factor = hsl_pkg::FACT_W'(six_pos);
    end else if (two_pos < one_x) begin
      c.seg    = hsl_pkg::SEG_HIGH;
      c.factor = '0;
    end else if (three_pos < (one_x << 1)) begin
      c.seg    = hsl_pkg::SEG_FALL;
      c.factor = hsl_pkg::FACT_W'(six_rest);
    end else begin
      c.seg    = hsl_pkg::SEG_LOW;
      c.factor = '0;
    end
    if (gray) begin
      c.seg = hsl_pkg::SEG_LOW;
      c.lo  = gray_l;
    end
    return c;
  endfunction

  always_comb begin
    sum_hi = (FW + 1)'(prep_i.l) + (FW + 1)'(prep_i.s) - (FW + 1)'(prep_i.prod_b);
    v2     = prep_i.lit_low ? prep_i.prod_a : FW'(sum_hi);
    dbl_l  = {prep_i.l, 1'b0};
    v1     = FW'(dbl_l - (FW + 1)'(v2));
    span   = (v2 > v1) ? v2 - v1 : '0;

    h_fx    = FW'(prep_i.h);
    pos_red = h_fx + hsl_pkg::FX_THIRD;
    if (pos_red > hsl_pkg::FX_ONE) begin
      pos_red = pos_red - hsl_pkg::FX_ONE;
    end
    pos_green = h_fx;
    pos_blue  = (h_fx < hsl_pkg::FX_THIRD) ? h_fx + hsl_pkg::FX_ONE - hsl_pkg::FX_THIRD
                                           : h_fx - hsl_pkg::FX_THIRD;

    chan_nxt[0] = make_chan(pos_red,   v1, v2, span, prep_i.l, prep_i.gray);
    chan_nxt[1] = make_chan(pos_green, v1, v2, span, prep_i.l, prep_i.gray);
    chan_nxt[2] = make_chan(pos_blue,  v1, v2, span, prep_i.l, prep_i.gray);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan_o = chan_r;

endmodule

`default_nettype wire

>>> rtl/hsl_ramp.sv
// Stage 3: one channel's hue ramp value from its segment and scaled chroma span.
`timescale 1ns / 1ps
`default_nettype none

module hsl_ramp (
  input  wire                          clk,
  input  wire                          en,
  input  wire hsl_pkg::chan_t          chan_i,
  output logic [hsl_pkg::VAL_W-1:0]    val_o
);

  localparam int PR_W = hsl_pkg::FX_W + hsl_pkg::FACT_W;

  logic [PR_W-1:0]            prod;
  logic [hsl_pkg::VAL_W-1:0]  scaled;
  logic [hsl_pkg::VAL_W-1:0]  val_nxt;
  logic [hsl_pkg::VAL_W-1:0]  val_r;

  always_comb begin
    prod   = PR_W'(chan_i.span) * PR_W'(chan_i.factor);
    scaled = prod[hsl_pkg::FRAC_BITS +: hsl_pkg::VAL_W];
    unique case (chan_i.seg)
      hsl_pkg::SEG_RISE,
      hsl_pkg::SEG_FALL: val_nxt = hsl_pkg::VAL_W'(chan_i.lo) + scaled;
      hsl_pkg::SEG_HIGH: val_nxt = hsl_pkg::VAL_W'(chan_i.hi);
      hsl_pkg::SEG_LOW:  val_nxt = hsl_pkg::VAL_W'(chan_i.lo);
      default:           val_nxt = hsl_pkg::VAL_W'(chan_i.lo);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
    end
  end

  assign val_o = val_r;

endmodule

`default_nettype wire

>>> rtl/hsl_level.sv
// Stage 4: scale a channel fraction to an 8-bit level with truncation and clamp.
`timescale 1ns / 1ps
`default_nettype none

module hsl_level (
  input  wire                          clk,
  input  wire                          en,
  input  wire [hsl_pkg::VAL_W-1:0]     val_i,
  output logic [hsl_pkg::LVL_W-1:0]    level_o
);

  localparam int M_W  = hsl_pkg::VAL_W + hsl_pkg::LVL_W;
  localparam int LV_W = M_W - hsl_pkg::FRAC_BITS;

  logic [M_W-1:0]             prod;
  logic [LV_W-1:0]            lvl;
  logic [hsl_pkg::LVL_W-1:0]  level_nxt;
  logic [hsl_pkg::LVL_W-1:0]  level_r;

  always_comb begin
    prod      = M_W'(val_i) * M_W'(hsl_pkg::LVL_MAX);
    lvl       = prod[hsl_pkg::FRAC_BITS +: LV_W];
    level_nxt = (lvl > LV_W'(hsl_pkg::LVL_MAX)) ? hsl_pkg::LVL_MAX : lvl[hsl_pkg::LVL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level_r <= level_nxt;
    end
  end

  assign level_o = level_r;

endmodule

`default_nettype wire

>>> rtl/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter: four-stage pipeline and flow control.
//
// Converts one color per clock while in_stall is low: a transaction on the input channel
// carries hue in degrees and saturation/lightness with 256 meaning 1.0; the red, green
// and blue levels appear on the output registers after passing the four register stages
// (normalize and multiply, chroma and segment select, ramp multiply, level scale), each
// of which takes a new color every clock that it is free to advance. out_stall holds the
// pipeline in place; empty stages still fill while stalled, so up to four colors are
// held, and in_stall rises only when every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module hsl_to_rgb_converter (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [hsl_pkg::IN_W-1:0]      in_hue_degrees,
  input  wire [hsl_pkg::IN_W-1:0]      in_saturation,
  input  wire [hsl_pkg::IN_W-1:0]      in_lightness,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [hsl_pkg::LVL_W-1:0]    out_red_level,
  output logic [hsl_pkg::LVL_W-1:0]    out_green_level,
  output logic [hsl_pkg::LVL_W-1:0]    out_blue_level
);

  localparam int STAGES = 4;

  logic [STAGES-1:0]          vld_r;
  logic [STAGES-1:0]          vld_nxt;
  logic [STAGES-1:0]          adv;
  hsl_pkg::prep_t             prep;
  hsl_pkg::chan_t [2:0]       chan;
  logic [hsl_pkg::VAL_W-1:0]  val [3];
  logic [hsl_pkg::LVL_W-1:0]  level [3];

  // a stage loads when it is empty or its contents move on
  always_comb begin
    adv[STAGES-1] = !vld_r[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[STAGES-1];

  hsl_prep u_prep (
    .clk         (clk),
    .en          (adv[0]),
    .hue_degrees (in_hue_degrees),
    .saturation  (in_saturation),
    .lightness   (in_lightness),
    .prep_o      (prep)
  );

  hsl_chroma u_chroma (
    .clk    (clk),
    .en     (adv[1]),
    .prep_i (prep),
    .chan_o (chan)
  );

  for (genvar c = 0; c < 3; c++) begin : g_chan
    hsl_ramp u_ramp (
      .clk    (clk),
      .en     (adv[2]),
      .chan_i (chan[c]),
      .val_o  (val[c])
    );

    hsl_level u_level (
      .clk     (clk),
      .en      (adv[3]),
      .val_i   (val[c]),
      .level_o (level[c])
    );
  end

  assign out_red_level   = level[0];
  assign out_green_level = level[1];
  assign out_blue_level  = level[2];

endmodule

`default_nettype wire
